FILE: sv/framed_message_rx_queue_top_assert.svh
// Assertion macros used by the receive queue datapath
`ifndef FRAMED_MESSAGE_RX_QUEUE_TOP_ASSERT_SVH
`define FRAMED_MESSAGE_RX_QUEUE_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define FMRQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define FMRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/fmrq_pkg.sv
// Package: sizes, codes and control types of the receive queue
package fmrq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int NIB_W       = 4;
    localparam int MSG_W       = 4 * NIB_W;
    localparam int MIN_LEN     = 3;

    localparam logic [NIB_W-1:0] HDR_NIBBLE = 4'hF;
    localparam logic [NIB_W-1:0] TRL_NIBBLE = 4'hE;
    localparam logic [NIB_W-1:0] CNT_SAT    = 4'hF;

    typedef enum logic [1:0] {
        REQ_RECV  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_BAD_HDR = 3'd1,
        ST_BAD_TRL = 3'd2,
        ST_FULL    = 3'd3,
        ST_SHORT   = 3'd4,
        ST_READ_OK = 3'd5,
        ST_EMPTY   = 3'd6,
        ST_CLEARED = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_RDWAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    cap_in;
        logic    set_st;
        status_t st_code;
        logic    scan_init;
        logic    scan_step;
        logic    store;
        logic    pop;
        logic    clear;
        logic    cap_msg;
        logic    load_out;
    } fmrq_cmd_t;

    typedef struct packed {
        req_t req;
        logic len_short;
        logic hdr_bad;
        logic trl_bad;
        logic rp_pending;
        logic scan_pending;
        logic scan_last;
        logic out_free;
    } fmrq_stat_t;

endpackage

FILE: sv/fmrq_ram.sv
// Generic single-write, single-read RAM with registered read data
module fmrq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/fmrq_ctrl.sv
// Controller state machine of the receive queue
module fmrq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fmrq_pkg::fmrq_stat_t stat,
    output fmrq_pkg::fmrq_cmd_t  cmd
);
    import fmrq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_EVAL;
            end
            S_EVAL: begin
                unique case (stat.req)
                    REQ_RECV: begin
                        if (stat.len_short || stat.hdr_bad || stat.trl_bad) begin
                            state_next = S_DONE;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    REQ_READ: state_next = stat.rp_pending ? S_RDWAIT : S_DONE;
                    default:  state_next = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (!stat.scan_pending || stat.scan_last) state_next = S_DONE;
            end
            S_RDWAIT: state_next = S_DONE;
            S_DONE: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.st_code = ST_SHORT;
        s_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.cap_in = s_valid;
            end
            S_EVAL: begin
                unique case (stat.req)
                    REQ_RECV: begin
                        if (stat.len_short) begin
                            cmd.set_st  = 1'b1;
                            cmd.st_code = ST_SHORT;
                        end else if (stat.hdr_bad) begin
                            cmd.set_st  = 1'b1;
                            cmd.st_code = ST_BAD_HDR;
                        end else if (stat.trl_bad) begin
                            cmd.set_st  = 1'b1;
                            cmd.st_code = ST_BAD_TRL;
                        end else begin
                            cmd.scan_init = 1'b1;
                        end
                    end
                    REQ_READ: begin
                        cmd.set_st = 1'b1;
                        if (stat.rp_pending) begin
                            cmd.pop     = 1'b1;
                            cmd.st_code = ST_READ_OK;
                        end else begin
                            cmd.st_code = ST_EMPTY;
                        end
                    end
                    REQ_CLEAR: begin
                        cmd.clear   = 1'b1;
                        cmd.set_st  = 1'b1;
                        cmd.st_code = ST_CLEARED;
                    end
                    default: begin
                        cmd.set_st  = 1'b1;
                        cmd.st_code = ST_SHORT;
                    end
                endcase
            end
            S_SCAN: begin
                if (!stat.scan_pending) begin
                    cmd.store   = 1'b1;
                    cmd.set_st  = 1'b1;
                    cmd.st_code = ST_STORED;
                end else if (stat.scan_last) begin
                    cmd.set_st  = 1'b1;
                    cmd.st_code = ST_FULL;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_RDWAIT: cmd.cap_msg = 1'b1;
            S_DONE:   cmd.load_out = stat.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

FILE: sv/fmrq_dp.sv
// Datapath of the receive queue: request registers, pending marks, slot store, result register
`include "framed_message_rx_queue_top_assert.svh"
module fmrq_dp (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic [1:0]                               s_req_type,
    input  logic [7:0]                               s_frame_len,
    input  logic [7:0]                               s_frame_byte0,
    input  logic [7:0]                               s_frame_byte1,
    input  logic [7:0]                               s_frame_byte2,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [2:0]                               m_status,
    output logic [fmrq_pkg::NIB_W-1:0]               m_msg_kind,
    output logic [fmrq_pkg::NIB_W-1:0]               m_msg_val1,
    output logic [fmrq_pkg::NIB_W-1:0]               m_msg_val2,
    output logic [fmrq_pkg::NIB_W-1:0]               m_msg_val3,
    output logic [fmrq_pkg::NIB_W-1:0]               m_pending_count,
    input  fmrq_pkg::fmrq_cmd_t                      cmd,
    output fmrq_pkg::fmrq_stat_t                     stat
);
    import fmrq_pkg::*;

    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);

    logic [1:0]             req_reg;
    logic [7:0]             len_reg;
    logic [7:0]             byte0_reg;
    logic [7:0]             byte1_reg;
    logic [7:0]             byte2_reg;
    logic [QUEUE_DEPTH-1:0] pending_reg;
    logic [PTR_W-1:0]       rp_reg;
    logic [PTR_W-1:0]       scan_idx_reg;
    logic [PTR_W-1:0]       scan_cnt_reg;
    logic [CNT_W-1:0]       cnt_reg;
    status_t                status_reg;
    logic [MSG_W-1:0]       msg_reg;
    logic                   m_valid_reg;
    logic [2:0]             m_status_reg;
    logic [MSG_W-1:0]       m_msg_reg;
    logic [NIB_W-1:0]       m_count_reg;

    logic [MSG_W-1:0]       wr_msg;
    logic [MSG_W-1:0]       rd_msg;
    logic [CNT_W+NIB_W-1:0] cnt_ext;
    logic [NIB_W-1:0]       cnt_sat;

    assign wr_msg  = {byte0_reg[3:0], byte1_reg, byte2_reg[7:4]};
    assign cnt_ext = (CNT_W + NIB_W)'(cnt_reg);
    assign cnt_sat = (cnt_ext > (CNT_W + NIB_W)'(CNT_SAT)) ? CNT_SAT : NIB_W'(cnt_reg);

    fmrq_ram #(
        .WIDTH (MSG_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (cmd.store),
        .wr_addr (scan_idx_reg),
        .wr_data (wr_msg),
        .rd_addr (rp_reg),
        .rd_data (rd_msg)
    );

    // request capture, status and message build, scan index and result register load
    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            req_reg   <= s_req_type;
            len_reg   <= s_frame_len;
            byte0_reg <= s_frame_byte0;
            byte1_reg <= s_frame_byte1;
            byte2_reg <= s_frame_byte2;
        end
        if (cmd.set_st) begin
            status_reg <= cmd.st_code;
            msg_reg    <= '0;
        end
        if (cmd.cap_msg) begin
            msg_reg <= rd_msg;
        end
        if (cmd.scan_init) begin
            scan_idx_reg <= rp_reg;
            scan_cnt_reg <= '0;
        end else if (cmd.scan_step) begin
            scan_idx_reg <= (scan_idx_reg == LAST_IDX) ? '0 : scan_idx_reg + 1'b1;
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
        end
        if (cmd.load_out) begin
            m_status_reg <= status_reg;
            m_msg_reg    <= msg_reg;
            m_count_reg  <= cnt_sat;
        end
    end

    // pending marks, read pointer and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            rp_reg      <= '0;
            cnt_reg     <= '0;
        end else if (cmd.clear) begin
            pending_reg <= '0;
            cnt_reg     <= '0;
        end else if (cmd.store) begin
            pending_reg[scan_idx_reg] <= 1'b1;
            cnt_reg                   <= cnt_reg + 1'b1;
        end else if (cmd.pop) begin
            pending_reg[rp_reg] <= 1'b0;
            rp_reg              <= (rp_reg == LAST_IDX) ? '0 : rp_reg + 1'b1;
            cnt_reg             <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        stat              = '0;
        stat.req          = req_t'(req_reg);
        stat.len_short    = (len_reg < 8'(MIN_LEN));
        stat.hdr_bad      = (byte0_reg[7:4] != HDR_NIBBLE);
        stat.trl_bad      = (byte2_reg[3:0] != TRL_NIBBLE);
        stat.rp_pending   = pending_reg[rp_reg];
        stat.scan_pending = pending_reg[scan_idx_reg];
        stat.scan_last    = (scan_cnt_reg == LAST_IDX);
        stat.out_free     = !m_valid_reg || m_ready;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_msg_kind      = m_msg_reg[4*NIB_W-1:3*NIB_W];
    assign m_msg_val1      = m_msg_reg[3*NIB_W-1:2*NIB_W];
    assign m_msg_val2      = m_msg_reg[2*NIB_W-1:NIB_W];
    assign m_msg_val3      = m_msg_reg[NIB_W-1:0];
    assign m_pending_count = m_count_reg;

    `FMRQ_ASSERT_SAME(a_count_tracks_marks, 1'b1,
        cnt_reg == CNT_W'($countones(pending_reg)), "pending count out of step with marks")
    `FMRQ_ASSERT_SAME(a_store_free_slot, cmd.store,
        !pending_reg[scan_idx_reg], "store into a pending slot")
    `FMRQ_ASSERT_NEXT(a_pop_clears_mark, cmd.pop,
        !pending_reg[$past(rp_reg)], "popped slot still pending")
    `FMRQ_ASSERT_SAME(a_load_when_free, cmd.load_out,
        !m_valid_reg || m_ready, "result register overwritten while held")

endmodule

FILE: sv/framed_message_rx_queue_top.sv
// Top level of the framed message receive queue
//
//   channel | direction | handshake           | payload
//   s_      | in        | s_valid / s_ready   | req_type, frame_len, frame_byte0..2
//   m_      | out       | m_valid / m_ready   | status, msg_kind, msg_val1..3, pending_count
//
// One request at a time. A receive that passes the frame checks scans one slot
// per cycle from the read pointer until it finds a free slot or has tried every slot;
// a read that pops passes through a wait state for the slot RAM read data.
// Reset (aresetn low, synchronous) drops all pending marks and zeroes the read pointer.
// A result waits in the output register; when it is not taken, the next request
// is still accepted and held at its end until the register frees up.
module framed_message_rx_queue_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [7:0] s_frame_len,
    input  logic [7:0] s_frame_byte0,
    input  logic [7:0] s_frame_byte1,
    input  logic [7:0] s_frame_byte2,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [3:0] m_msg_kind,
    output logic [3:0] m_msg_val1,
    output logic [3:0] m_msg_val2,
    output logic [3:0] m_msg_val3,
    output logic [3:0] m_pending_count
);
    import fmrq_pkg::*;

    fmrq_cmd_t  cmd;
    fmrq_stat_t stat;

    fmrq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fmrq_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_req_type      (s_req_type),
        .s_frame_len     (s_frame_len),
        .s_frame_byte0   (s_frame_byte0),
        .s_frame_byte1   (s_frame_byte1),
        .s_frame_byte2   (s_frame_byte2),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_msg_kind      (m_msg_kind),
        .m_msg_val1      (m_msg_val1),
        .m_msg_val2      (m_msg_val2),
        .m_msg_val3      (m_msg_val3),
        .m_pending_count (m_pending_count),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the framed message receive queue
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fmrq_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int ERR_SHOW    = 10;

    typedef struct packed {
        status_t           status;
        logic [NIB_W-1:0]  kind;
        logic [NIB_W-1:0]  val1;
        logic [NIB_W-1:0]  val2;
        logic [NIB_W-1:0]  val3;
        logic [3:0]        count;
    } queue_result_t;

    logic       aclk;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [1:0] s_req_type    = REQ_NONE;
    logic [7:0] s_frame_len   = '0;
    logic [7:0] s_frame_byte0 = '0;
    logic [7:0] s_frame_byte1 = '0;
    logic [7:0] s_frame_byte2 = '0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [2:0] m_status;
    logic [3:0] m_msg_kind;
    logic [3:0] m_msg_val1;
    logic [3:0] m_msg_val2;
    logic [3:0] m_msg_val3;
    logic [3:0] m_pending_count;

    // shadow copy of the queue
    logic [QUEUE_DEPTH-1:0] slot_busy = '0;
    logic [MSG_W-1:0]       slot_msg [QUEUE_DEPTH];
    int                     rd_ptr    = 0;

    queue_result_t expected_results[$];
    int            mismatch_count = 0;
    int            send_idle_pct  = 0;
    int            stall_pct      = 0;
    logic          hold_off       = 1'b0;
    int            quiet_cycles   = 0;

    framed_message_rx_queue_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_frame_len    (s_frame_len),
        .s_frame_byte0  (s_frame_byte0),
        .s_frame_byte1  (s_frame_byte1),
        .s_frame_byte2  (s_frame_byte2),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_msg_kind     (m_msg_kind),
        .m_msg_val1     (m_msg_val1),
        .m_msg_val2     (m_msg_val2),
        .m_msg_val3     (m_msg_val3),
        .m_pending_count(m_pending_count)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Compute the result of one request and advance the shadow queue.
    function automatic void predict_queue(req_t req, logic [7:0] len, logic [7:0] b0,
                                          logic [7:0] b1, logic [7:0] b2);
        queue_result_t r;
        int            slot;
        int            n;
        r = '0;
        r.status = ST_SHORT;
        case (req)
            REQ_RECV: begin
                if (len < MIN_LEN) begin
                    r.status = ST_SHORT;
                end else if (b0[7:4] != HDR_NIBBLE) begin
                    r.status = ST_BAD_HDR;
                end else if (b2[3:0] != TRL_NIBBLE) begin
                    r.status = ST_BAD_TRL;
                end else begin
                    r.status = ST_FULL;
                    for (int i = 0; i < QUEUE_DEPTH; i++) begin
                        slot = (rd_ptr + i) % QUEUE_DEPTH;
                        if (!slot_busy[slot]) begin
                            slot_msg[slot]  = {b0[3:0], b1, b2[7:4]};
                            slot_busy[slot] = 1'b1;
                            r.status = ST_STORED;
                            break;
                        end
                    end
                end
            end
            REQ_READ: begin
                // pop only when the slot under the read pointer holds a message
                if (slot_busy[rd_ptr]) begin
                    {r.kind, r.val1, r.val2, r.val3} = slot_msg[rd_ptr];
                    slot_busy[rd_ptr] = 1'b0;
                    rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
                    r.status = ST_READ_OK;
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            REQ_CLEAR: begin
                slot_busy = '0;
                r.status = ST_CLEARED;
            end
            default: r.status = ST_SHORT;
        endcase
        n = $countones(slot_busy);
        r.count = (n > 15) ? CNT_SAT : 4'(n);
        expected_results.push_back(r);
    endfunction

    // Offer one request and hold it until accepted.
    task automatic send_request(req_t req, logic [7:0] len, logic [7:0] b0,
                                logic [7:0] b1, logic [7:0] b2);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_frame_len   <= len;
        s_frame_byte0 <= b0;
        s_frame_byte1 <= b1;
        s_frame_byte2 <= b2;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_queue(req, len, b0, b1, b2);
    endtask

    task automatic send_good_frame(logic [7:0] len, logic [3:0] kind, logic [7:0] vals,
                                   logic [3:0] v3);
        send_request(REQ_RECV, len, {HDR_NIBBLE, kind}, vals, {v3, TRL_NIBBLE});
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        stall_pct    <= recv_pct;
    endtask

    // Mostly well-formed traffic, with noise and broken frames mixed in.
    task automatic random_requests(int count, int recv_pct);
        int roll;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < recv_pct) begin
                send_good_frame(8'($urandom_range(255, MIN_LEN)), 4'($urandom),
                                8'($urandom), 4'($urandom));
            end else if (roll < 88) begin
                send_request(REQ_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom));
            end else if (roll < 91) begin
                send_request(REQ_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom));
            end else begin
                case ($urandom_range(3))
                    0: send_request(REQ_RECV, 8'($urandom_range(MIN_LEN - 1)),
                                    {HDR_NIBBLE, 4'($urandom)}, 8'($urandom),
                                    {4'($urandom), TRL_NIBBLE});
                    1: send_request(REQ_RECV, 8'($urandom_range(255, MIN_LEN)),
                                    {HDR_NIBBLE, 4'($urandom)}, 8'($urandom), 8'($urandom));
                    2: send_request(REQ_RECV, 8'($urandom), 8'($urandom), 8'($urandom),
                                    8'($urandom));
                    default: send_request(REQ_NONE, 8'($urandom), 8'($urandom),
                                          8'($urandom), 8'($urandom));
                endcase
            end
        end
    endtask

    task automatic test_directed();
        set_idling(0, 0);
        send_request(REQ_READ, 8'd0, 8'h00, 8'h00, 8'h00);
        send_request(REQ_RECV, 8'd0, 8'hF1, 8'h23, 8'h4E);
        send_request(REQ_RECV, 8'd1, 8'hF1, 8'h23, 8'h4E);
        send_request(REQ_RECV, 8'd2, 8'hF1, 8'h23, 8'h4E);
        send_request(REQ_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // both framing nibbles wrong: header wins
        send_request(REQ_RECV, 8'd3, 8'h00, 8'h00, 8'h00);
        send_request(REQ_RECV, 8'd3, 8'hEF, 8'hFF, 8'hFE);
        send_request(REQ_RECV, 8'd3, 8'hF0, 8'h00, 8'h0F);
        // fill every slot, then one more
        send_good_frame(8'd3,   4'h0, 8'h00, 4'h0);
        send_good_frame(8'd255, 4'hF, 8'hFF, 4'hF);
        send_good_frame(8'd250, 4'h1, 8'h23, 4'h4);
        send_good_frame(8'd128, 4'hA, 8'h5C, 4'h3);
        send_good_frame(8'd4,   4'h7, 8'h0F, 4'hF);
        send_good_frame(8'd127, 4'h8, 8'hF0, 4'h0);
        send_good_frame(8'd64,  4'h5, 8'hAA, 4'h5);
        send_good_frame(8'd3,   4'h3, 8'h96, 4'hC);
        send_good_frame(8'd3,   4'h9, 8'h99, 4'h9);
        send_request(REQ_READ, 8'd0, 8'h00, 8'h00, 8'h00);
        send_request(REQ_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(REQ_CLEAR, 8'd0, 8'h00, 8'h00, 8'h00);
        send_request(REQ_READ, 8'd0, 8'h00, 8'h00, 8'h00);
        // after a clear the read pointer stays where it was
        send_good_frame(8'd3, 4'hC, 8'h3D, 4'hE);
        send_request(REQ_READ, 8'd0, 8'h00, 8'h00, 8'h00);
        send_request(REQ_READ, 8'd0, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_no_idle();
        set_idling(0, 0);
        random_requests(300, 60);
    endtask

    task automatic test_sender_idle();
        set_idling(78, 0);
        random_requests(200, 45);
    endtask

    task automatic test_receiver_stall();
        set_idling(0, 78);
        random_requests(200, 55);
    endtask

    task automatic test_both_idle();
        set_idling(23, 23);
        random_requests(250, 50);
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        fork
            begin
                hold_off <= 1'b1;
                repeat (300) @(posedge aclk);
                hold_off <= 1'b0;
            end
            random_requests(100, 60);
        join
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4 * QUEUE_DEPTH) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    always @(posedge aclk) begin : result_check
        queue_result_t got;
        queue_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {status_t'(m_status), m_msg_kind, m_msg_val1, m_msg_val2, m_msg_val3,
                   m_pending_count};
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= ERR_SHOW)
                    $display("unexpected result: status %0d kind %h vals %h %h %h count %0d",
                             got.status, got.kind, got.val1, got.val2, got.val3, got.count);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.kind !== want.kind ||
                    got.val1 !== want.val1 || got.val2 !== want.val2 ||
                    got.val3 !== want.val3 || got.count !== want.count) begin
                    mismatch_count++;
                    if (mismatch_count <= ERR_SHOW) begin
                        $write("mismatch at %0t: expected status %0d msg %h%h%h%h count %0d,",
                               $realtime, want.status, want.kind, want.val1, want.val2,
                               want.val3, want.count);
                        $display(" got status %0d msg %h%h%h%h count %0d", got.status,
                                 got.kind, got.val1, got.val2, got.val3, got.count);
                    end
                end
            end
        end
        m_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

FILE: framed_message_rx_queue_top.f
+incdir+sv
sv/fmrq_pkg.sv
sv/fmrq_ram.sv
sv/fmrq_ctrl.sv
sv/fmrq_dp.sv
sv/framed_message_rx_queue_top.sv
bench/testbench.sv
